// ----- rtl/core/gpsbcd_pkg.sv -----
// Package for the GPS fix to BCD telemetry frame packer.
// Holds frame constants, the pipeline stage type and the constant-divide and BCD helpers.
// No dependencies.
`timescale 1ns / 1ps

package gpsbcd_pkg;

    localparam int unsigned IN_W  = 136;
    localparam int unsigned OUT_W = 256;
    localparam int unsigned PIPE_STAGES = 8;

    localparam logic [7:0] TAG_A         = 8'h16;
    localparam logic [7:0] TAG_B         = 8'h17;
    localparam logic [7:0] SIGN_FLAG     = 8'h01;
    localparam logic [7:0] WIDE_LON_FLAG = 8'h04;

    localparam logic [31:0] ONE_E7      = 32'd10000000;
    localparam logic [20:0] KNOT_FACTOR = 21'd1943844;
    localparam logic [15:0] ALT_SPLIT   = 16'd10000;
    // bias that makes altitude positive; a multiple of 100 whose low 16 quotient bits are zero
    localparam logic [32:0] ALT_BIAS    = 33'd3355443200;

    // reciprocals: ceil(2^k / d), exact over the operand ranges used here
    localparam logic [25:0] RCP_E7_42   = 26'd56294996;    // x[31:7] / 78125, k = 42
    localparam logic [30:0] RCP_E7_47   = 31'd1801439851;  // x[29:0] / 78125, k = 47
    localparam logic [31:0] RCP_25_36   = 32'd2748779070;  // x / 25, k = 36
    localparam logic [12:0] RCP_25_17   = 13'd5243;        // x / 25, k = 17
    localparam logic [15:0] RCP_5_18    = 16'd52429;       // x / 5, k = 18

    typedef struct packed {
        logic        lat_neg;
        logic        lon_neg;
        logic [31:0] lat_x;
        logic [31:0] lon_x;
        logic [7:0]  lat_deg;
        logic [7:0]  lat_mn;
        logic [7:0]  lat_sc;
        logic [7:0]  lat_sub;
        logic [7:0]  lon_deg;
        logic [7:0]  lon_mn;
        logic [7:0]  lon_sc;
        logic [7:0]  lon_sub;
        logic [15:0] alt;
        logic [7:0]  superalt;
        logic [36:0] spd_prod;
        logic [13:0] speed;
        logic [7:0]  spd_hi;
        logic [6:0]  spd_lo;
        logic [12:0] heading;
        logic [7:0]  hd_hi;
        logic [6:0]  hd_lo;
        logic [7:0]  sats;
    } pipe_t;

    // quotient by 1e7 for values below 2^31 + 1, result at most 214
    function automatic logic [7:0] div_e7(input logic [31:0] x);
        logic [50:0] prod;
        prod = x[31:7] * RCP_E7_42;
        return prod[49:42];
    endfunction

    // remainder after the digit is taken off, then scaled for the next digit pair
    function automatic logic [31:0] rem_scale(input logic [31:0] x, input logic [7:0] q,
                                              input logic [6:0] scale);
        logic [31:0] rem;
        rem = x - {24'd0, q} * ONE_E7;
        return rem * {25'd0, scale};
    endfunction

    // quotient by 100 for values below 2^14
    function automatic logic [7:0] div_100(input logic [13:0] s);
        logic [24:0] prod;
        prod = s[13:2] * RCP_25_17;
        return prod[24:17];
    endfunction

    // two BCD digits of an 8-bit value; tens above 9 wrap into the byte
    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [15:0] prod;
        logic [4:0]  t;
        logic [7:0]  u;
        prod = {8'd0, v} * 16'd205;
        t    = prod[15:11];
        u    = v - {3'd0, t} * 8'd10;
        return {t[3:0], 4'd0} + u;
    endfunction

    function automatic logic [7:0] alt_tens_k(input logic [15:0] a);
        logic [7:0] k;
        k = 8'd1;
        for (int i = 2; i <= 6; i++)
        begin
            if (a >= 16'(i) * ALT_SPLIT)
            begin
                k = 8'(i);
            end
        end
        return k;
    endfunction

endpackage

// ----- rtl/core/gps_fix_to_bcd_telemetry_frames.sv -----
// Top level: packs one GPS fix into two 16-byte BCD telemetry frames (tags 0x16, 0x17).
// Depends on gpsbcd_pkg for constants, the stage type and divide/BCD helpers.
// Throughput: one fix per cycle while the master side does not stall; the eight-stage
// coordinate digit chain sets the depth, alternating one reciprocal-multiply stage and one
// remainder-scale stage per digit pair.
// A stall on the master side holds every stage; nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) clears all stage valid bits and the output valid.
`timescale 1ns / 1ps

module gps_fix_to_bcd_telemetry_frames (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // latitude[30:0], longitude[62:31], altitude_mm[94:63], ground_speed[110:95],
    // course[126:111], satellites[134:127], zero pad[135]
    input  logic [gpsbcd_pkg::IN_W-1:0]     s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // frame_a_low[63:0], frame_a_high[127:64], frame_b_low[191:128], frame_b_high[255:192]
    output logic [gpsbcd_pkg::OUT_W-1:0]    m_tdata
);

    localparam int unsigned NS = gpsbcd_pkg::PIPE_STAGES;

    logic                          advance;
    logic [NS:1]                   vld_reg;
    gpsbcd_pkg::pipe_t             stg_reg  [1:NS];
    gpsbcd_pkg::pipe_t             stg_next [1:NS];
    logic                          out_valid_reg;
    logic [gpsbcd_pkg::OUT_W-1:0]  out_data_reg;
    logic [gpsbcd_pkg::OUT_W-1:0]  out_data_next;

    logic signed [30:0] lat_in;
    logic signed [31:0] lon_in;
    logic [32:0]        alt_u;
    logic [62:0]        alt_prod;
    logic [30:0]        hd_prod;
    logic [60:0]        sp_prod;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign lat_in = s_tdata[30:0];
    assign lon_in = s_tdata[62:31];

    always_comb
    begin
        // stage 1: magnitudes, altitude floor divide, speed product, course / 10
        stg_next[1]         = stg_reg[1];
        stg_next[1].lat_neg = lat_in[30];
        stg_next[1].lon_neg = lon_in[31];
        stg_next[1].lat_x   = lat_in[30] ? 32'(-33'(lat_in)) : 32'(lat_in);
        stg_next[1].lon_x   = lon_in[31] ? 32'(-33'(lon_in)) : 32'(lon_in);
        alt_u               = {s_tdata[94], s_tdata[94:63]} + gpsbcd_pkg::ALT_BIAS;
        alt_prod            = alt_u[32:2] * gpsbcd_pkg::RCP_25_36;
        stg_next[1].alt     = alt_prod[51:36];
        stg_next[1].spd_prod = s_tdata[110:95] * gpsbcd_pkg::KNOT_FACTOR;
        hd_prod             = s_tdata[126:112] * gpsbcd_pkg::RCP_5_18;
        stg_next[1].heading = hd_prod[30:18];
        stg_next[1].sats    = s_tdata[134:127];

        // stage 2: degrees, knots, altitude ten-thousands split
        stg_next[2]         = stg_reg[1];
        stg_next[2].lat_deg = gpsbcd_pkg::div_e7(stg_reg[1].lat_x);
        stg_next[2].lon_deg = gpsbcd_pkg::div_e7(stg_reg[1].lon_x);
        sp_prod             = stg_reg[1].spd_prod[36:7] * gpsbcd_pkg::RCP_E7_47;
        stg_next[2].speed   = sp_prod[60:47];
        stg_next[2].superalt = 8'd0;
        if (stg_reg[1].alt > gpsbcd_pkg::ALT_SPLIT)
        begin
            stg_next[2].superalt = gpsbcd_pkg::alt_tens_k(stg_reg[1].alt);
            stg_next[2].alt = stg_reg[1].alt
                - 16'(stg_next[2].superalt) * gpsbcd_pkg::ALT_SPLIT;
        end

        // stage 3: scale remainder for minutes, hundreds of knots and course degrees
        stg_next[3]         = stg_reg[2];
        stg_next[3].lat_x   = gpsbcd_pkg::rem_scale(stg_reg[2].lat_x, stg_reg[2].lat_deg, 7'd60);
        stg_next[3].lon_x   = gpsbcd_pkg::rem_scale(stg_reg[2].lon_x, stg_reg[2].lon_deg, 7'd60);
        stg_next[3].spd_hi  = gpsbcd_pkg::div_100(stg_reg[2].speed);
        stg_next[3].hd_hi   = gpsbcd_pkg::div_100({1'b0, stg_reg[2].heading});

        // stage 4: minutes, low pairs of knots and course
        stg_next[4]         = stg_reg[3];
        stg_next[4].lat_mn  = gpsbcd_pkg::div_e7(stg_reg[3].lat_x);
        stg_next[4].lon_mn  = gpsbcd_pkg::div_e7(stg_reg[3].lon_x);
        stg_next[4].spd_lo  = 7'(stg_reg[3].speed - 14'(stg_reg[3].spd_hi) * 14'd100);
        stg_next[4].hd_lo   = 7'(stg_reg[3].heading - 13'(stg_reg[3].hd_hi) * 13'd100);

        stg_next[5]         = stg_reg[4];
        stg_next[5].lat_x   = gpsbcd_pkg::rem_scale(stg_reg[4].lat_x, stg_reg[4].lat_mn, 7'd100);
        stg_next[5].lon_x   = gpsbcd_pkg::rem_scale(stg_reg[4].lon_x, stg_reg[4].lon_mn, 7'd100);

        stg_next[6]         = stg_reg[5];
        stg_next[6].lat_sc  = gpsbcd_pkg::div_e7(stg_reg[5].lat_x);
        stg_next[6].lon_sc  = gpsbcd_pkg::div_e7(stg_reg[5].lon_x);

        stg_next[7]         = stg_reg[6];
        stg_next[7].lat_x   = gpsbcd_pkg::rem_scale(stg_reg[6].lat_x, stg_reg[6].lat_sc, 7'd100);
        stg_next[7].lon_x   = gpsbcd_pkg::rem_scale(stg_reg[6].lon_x, stg_reg[6].lon_sc, 7'd100);

        stg_next[8]         = stg_reg[7];
        stg_next[8].lat_sub = gpsbcd_pkg::div_e7(stg_reg[7].lat_x);
        stg_next[8].lon_sub = gpsbcd_pkg::div_e7(stg_reg[7].lon_x);
    end

    // output stage: BCD conversion, flags and frame packing
    always_comb
    begin
        logic [7:0] flags;
        logic [7:0] lon_deg;
        flags   = 8'd0;
        lon_deg = stg_reg[NS].lon_deg;
        if (stg_reg[NS].lat_neg || stg_reg[NS].lon_neg)
        begin
            flags = flags | gpsbcd_pkg::SIGN_FLAG;
        end
        if (lon_deg > 8'd99)
        begin
            flags   = flags | gpsbcd_pkg::WIDE_LON_FLAG;
            lon_deg = lon_deg - 8'd100;
        end
        out_data_next = '0;
        out_data_next[7:0]     = gpsbcd_pkg::TAG_A;
        out_data_next[23:16]   = gpsbcd_pkg::to_bcd(stg_reg[NS].alt[7:0]);
        out_data_next[31:24]   = gpsbcd_pkg::to_bcd(stg_reg[NS].alt[15:8]);
        out_data_next[39:32]   = gpsbcd_pkg::to_bcd(stg_reg[NS].lat_sub);
        out_data_next[47:40]   = gpsbcd_pkg::to_bcd(stg_reg[NS].lat_sc);
        out_data_next[55:48]   = gpsbcd_pkg::to_bcd(stg_reg[NS].lat_mn);
        out_data_next[63:56]   = gpsbcd_pkg::to_bcd(stg_reg[NS].lat_deg);
        out_data_next[71:64]   = gpsbcd_pkg::to_bcd(stg_reg[NS].lon_sub);
        out_data_next[79:72]   = gpsbcd_pkg::to_bcd(stg_reg[NS].lon_sc);
        out_data_next[87:80]   = gpsbcd_pkg::to_bcd(stg_reg[NS].lon_mn);
        out_data_next[95:88]   = gpsbcd_pkg::to_bcd(lon_deg);
        out_data_next[103:96]  = gpsbcd_pkg::to_bcd({1'b0, stg_reg[NS].hd_lo});
        out_data_next[111:104] = gpsbcd_pkg::to_bcd(stg_reg[NS].hd_hi);
        out_data_next[127:120] = flags;
        out_data_next[135:128] = gpsbcd_pkg::TAG_B;
        out_data_next[151:144] = gpsbcd_pkg::to_bcd({1'b0, stg_reg[NS].spd_lo});
        out_data_next[159:152] = gpsbcd_pkg::to_bcd(stg_reg[NS].spd_hi);
        out_data_next[199:192] = stg_reg[NS].sats;
        out_data_next[207:200] = stg_reg[NS].superalt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg       <= {vld_reg[NS-1:1], s_tvalid};
            out_valid_reg <= vld_reg[NS];
        end
    end

    // payload: advance all stages together, hold on stall
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 1; i <= NS; i++)
            begin
                stg_reg[i] <= stg_next[i];
            end
            out_data_reg <= out_data_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_tags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:0] == gpsbcd_pkg::TAG_A)
                  && (m_tdata[135:128] == gpsbcd_pkg::TAG_B))
        else $error("frame tag bytes wrong");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[127:120]
            & ~(gpsbcd_pkg::SIGN_FLAG | gpsbcd_pkg::WIDE_LON_FLAG)) == 8'd0))
        else $error("undefined flag bit set");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!advance && vld_reg[NS]) |=> vld_reg[NS])
        else $error("last stage lost its transaction during stall");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NS] && advance) |=> m_tvalid)
        else $error("last stage advanced without producing output");
`endif

endmodule
